[rtl/jet_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, register indexes and types for the escape-time engine.
package jet_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 28;
  localparam int COORD_BITS = 12;
  localparam int ITER_BITS  = 16;
  localparam int PROD_W     = 2 * DATA_W;
  // candidate part before range check: shifted product plus c, two guard bits
  localparam int CAND_W     = PROD_W - FRAC_BITS + 2;
  // step times pixel index
  localparam int START_W    = DATA_W + COORD_BITS + 1;
  localparam int CFG_IDX_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_C_REAL    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_C_IMAG    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ESC_RAD   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_REAL  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_IMAG  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP = CFG_IDX_W'(7);

  localparam logic signed [DATA_W-1:0] RST_C        = '0;
  localparam logic [DATA_W-1:0]        RST_ESC_RAD  = 32'd1073741824;
  localparam logic [ITER_BITS-1:0]     RST_MAX_ITER = ITER_BITS'(255);
  localparam logic signed [DATA_W-1:0] RST_MIN      = -32'sd536870912;
  localparam logic signed [DATA_W-1:0] RST_STEP     = 32'sd262144;

  typedef struct packed {
    logic signed [DATA_W-1:0] c_real;
    logic signed [DATA_W-1:0] c_imag;
    logic [DATA_W-1:0]        esc_rad_sq;
    logic [ITER_BITS-1:0]     max_iter;
    logic signed [DATA_W-1:0] min_real;
    logic signed [DATA_W-1:0] min_imag;
    logic signed [DATA_W-1:0] real_step;
    logic signed [DATA_W-1:0] imag_step;
  } cfg_t;

  typedef struct packed {
    logic start;     // item accepted: form step products
    logic load;      // load start point, clear count
    logic mul;       // square current value
    logic eval;      // test candidate, form next one
    logic out_load;  // move result to output register
  } jet_cmd_t;

  typedef struct packed {
    logic stop;      // iteration ends in this evaluation
  } jet_sts_t;

endpackage

[rtl/jet_pix_if.sv]
`timescale 1ns / 1ps
// Pixel coordinate channel.
interface jet_pix_if;
  import jet_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

[rtl/jet_res_if.sv]
`timescale 1ns / 1ps
// Escape-count result channel.
interface jet_res_if;
  import jet_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ITER_BITS-1:0] iter_count;
  logic                 inside_res;

  modport source (output valid, output iter_count, output inside_res, input ready);
  modport sink (input valid, input iter_count, input inside_res, output ready);
endinterface

[rtl/jet_cfg.sv]
`timescale 1ns / 1ps
// Configuration register file with write decode.
module jet_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [jet_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jet_pkg::DATA_W-1:0]     cfg_data_i,
  output jet_pkg::cfg_t                  cfg_o
);
  import jet_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_C_REAL:    cfg_d.c_real     = cfg_data_i;
        REG_C_IMAG:    cfg_d.c_imag     = cfg_data_i;
        REG_ESC_RAD:   cfg_d.esc_rad_sq = cfg_data_i;
        REG_MAX_ITER:  cfg_d.max_iter   = cfg_data_i[ITER_BITS-1:0];
        REG_MIN_REAL:  cfg_d.min_real   = cfg_data_i;
        REG_MIN_IMAG:  cfg_d.min_imag   = cfg_data_i;
        REG_REAL_STEP: cfg_d.real_step  = cfg_data_i;
        REG_IMAG_STEP: cfg_d.imag_step  = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.c_real     <= RST_C;
      cfg_q.c_imag     <= RST_C;
      cfg_q.esc_rad_sq <= RST_ESC_RAD;
      cfg_q.max_iter   <= RST_MAX_ITER;
      cfg_q.min_real   <= RST_MIN;
      cfg_q.min_imag   <= RST_MIN;
      cfg_q.real_step  <= RST_STEP;
      cfg_q.imag_step  <= RST_STEP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/jet_dp.sv]
`timescale 1ns / 1ps
// Datapath: start-point mapping, complex square, escape test and result register.
module jet_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  jet_pkg::cfg_t                    cfg_i,
  input  jet_pkg::jet_cmd_t                cmd_i,
  output jet_pkg::jet_sts_t                sts_o,
  input  logic [jet_pkg::COORD_BITS-1:0]   pixel_x_i,
  input  logic [jet_pkg::COORD_BITS-1:0]   pixel_y_i,
  output logic [jet_pkg::ITER_BITS-1:0]    iter_count_o,
  output logic                             inside_res_o
);
  import jet_pkg::*;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic signed [START_W-1:0] sp_re_q, sp_im_q;
  logic signed [START_W:0]   st_re, st_im;
  logic signed [DATA_W-1:0]  st_re_sat, st_im_sat;
  logic signed [DATA_W-1:0]  zr_q, zi_q;
  logic signed [PROD_W-1:0]  prr_q, pii_q, pri_q;
  logic signed [PROD_W-1:0]  diff;
  logic signed [CAND_W-1:0]  cand_re, cand_im;
  logic                      fit_re, fit_im;
  logic [PROD_W-1:0]         mag;
  logic                      mag_sat;
  logic [DATA_W-1:0]         mag32;
  logic                      escape, limit;
  logic [ITER_BITS-1:0]      n_q, n_next;
  logic                      first_q;
  logic [ITER_BITS-1:0]      iter_count_q;
  logic                      inside_q;

  // start point, saturated to the data range
  assign st_re = (START_W+1)'(sp_re_q) + (START_W+1)'(cfg_i.min_real);
  assign st_im = (START_W+1)'(sp_im_q) + (START_W+1)'(cfg_i.min_imag);

  always_comb begin
    if (st_re[START_W:DATA_W-1] == '0 || st_re[START_W:DATA_W-1] == '1) begin
      st_re_sat = st_re[DATA_W-1:0];
    end else begin
      st_re_sat = st_re[START_W] ? SAT_MIN : SAT_MAX;
    end
    if (st_im[START_W:DATA_W-1] == '0 || st_im[START_W:DATA_W-1] == '1) begin
      st_im_sat = st_im[DATA_W-1:0];
    end else begin
      st_im_sat = st_im[START_W] ? SAT_MIN : SAT_MAX;
    end
  end

  // next candidate from the squares of the current value; 2*zr*zi via a shift one short
  assign diff    = prr_q - pii_q;
  assign cand_re = CAND_W'(diff >>> FRAC_BITS) + CAND_W'(cfg_i.c_real);
  assign cand_im = CAND_W'(pri_q >>> (FRAC_BITS - 1)) + CAND_W'(cfg_i.c_imag);
  assign fit_re  = (cand_re[CAND_W-1:DATA_W-1] == '0) || (cand_re[CAND_W-1:DATA_W-1] == '1);
  assign fit_im  = (cand_im[CAND_W-1:DATA_W-1] == '0) || (cand_im[CAND_W-1:DATA_W-1] == '1);

  // squares held are also those of the value under test
  assign mag     = $unsigned(prr_q) + $unsigned(pii_q);
  assign mag_sat = |mag[PROD_W-1:DATA_W+FRAC_BITS];
  assign mag32   = mag[DATA_W+FRAC_BITS-1:FRAC_BITS];

  // the start point is never tested
  assign escape = !first_q && (mag_sat || (mag32 > cfg_i.esc_rad_sq));
  assign n_next = first_q ? n_q : n_q + ITER_BITS'(1);
  assign limit  = n_next >= cfg_i.max_iter;

  assign sts_o.stop = escape || limit || !fit_re || !fit_im;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= '0;
      first_q <= 1'b0;
    end else if (cmd_i.load) begin
      n_q     <= '0;
      first_q <= 1'b1;
    end else if (cmd_i.eval) begin
      first_q <= 1'b0;
      if (!escape) begin
        n_q <= n_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sp_re_q <= START_W'(cfg_i.real_step) * START_W'(signed'({1'b0, pixel_x_i}));
      sp_im_q <= START_W'(cfg_i.imag_step) * START_W'(signed'({1'b0, pixel_y_i}));
    end
    if (cmd_i.load) begin
      zr_q <= st_re_sat;
      zi_q <= st_im_sat;
    end else if (cmd_i.eval && !sts_o.stop) begin
      zr_q <= cand_re[DATA_W-1:0];
      zi_q <= cand_im[DATA_W-1:0];
    end
    if (cmd_i.mul) begin
      prr_q <= PROD_W'(zr_q) * PROD_W'(zr_q);
      pii_q <= PROD_W'(zi_q) * PROD_W'(zi_q);
      pri_q <= PROD_W'(zr_q) * PROD_W'(zi_q);
    end
    if (cmd_i.out_load) begin
      iter_count_q <= n_q;
      inside_q     <= n_q >= cfg_i.max_iter;
    end
  end

  assign iter_count_o = iter_count_q;
  assign inside_res_o = inside_q;

endmodule

[rtl/jet_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences one item through the datapath and owns the result valid.
module jet_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  jet_pkg::jet_sts_t  sts_i,
  output jet_pkg::jet_cmd_t  cmd_o
);
  import jet_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       res_valid_q, res_valid_d;
  logic       out_free;

  assign out_free   = !res_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.start    = in_valid_i && in_ready_o;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.stop ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        // wait for room in the output register
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      res_valid_d = 1'b1;
    end else if (out_ready_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign out_valid_o = res_valid_q;

endmodule

[rtl/julia_escape_time_engine.sv]
`timescale 1ns / 1ps
// An accepted item passes LOAD, then MUL and EVAL once per iteration, then DONE, where it waits
// while the output register still holds a result that is not taken.
// MUL forms the three 32x32 products and EVAL does the test and update.
// One item is worked on at a time; the next can be accepted once the result has entered the
// output register. Asynchronous active-low reset clears the controller, result valid and
// count, and loads the configuration with its reset values.
module julia_escape_time_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  jet_pix_if.sink                        pix_i,
  jet_res_if.source                      res_o,
  input  logic                           cfg_we_i,
  input  logic [jet_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jet_pkg::DATA_W-1:0]     cfg_data_i
);
  import jet_pkg::*;

  cfg_t     cfg;
  jet_cmd_t cmd;
  jet_sts_t sts;

  jet_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  jet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  jet_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pixel_x_i    (pix_i.pixel_x),
    .pixel_y_i    (pix_i.pixel_y),
    .iter_count_o (res_o.iter_count),
    .inside_res_o (res_o.inside_res)
  );

endmodule

[rtl/jet_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the escape-time engine, with its bind.
module jet_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [jet_pkg::ITER_BITS-1:0] iter_count_i,
  input logic                          inside_res_i
);
  import jet_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // items accepted whose result has not yet been taken
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(iter_count_i)
      && $stable(inside_res_i))
    else $error("result changed while stalled");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two items in flight");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without an accepted item");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !in_ready_i)
    else $error("input ready with work and output both occupied");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("second item taken while one is in work");

endmodule

bind julia_escape_time_engine jet_chk u_jet_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (pix_i.valid),
  .in_ready_i   (pix_i.ready),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .iter_count_i (res_o.iter_count),
  .inside_res_i (res_o.inside_res)
);
